[rtl/atrtm_pkg.sv]
// ============================================================================
// atrtm_pkg: shared types and constants for the response tag matcher
// Operation codes, result codes, register indexes and the fixed tag texts.
// ============================================================================
`default_nettype none

package atrtm_pkg;

    localparam int unsigned NUM_TAGS = 7;
    localparam int unsigned TAG_MAX  = 16;
    localparam int unsigned FIND_MAX = 16;
    localparam int unsigned TAG_BITS = 8 * TAG_MAX;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [3:0] CODE_FIND    = 4'd7;
    localparam logic [3:0] CODE_TIMEOUT = 4'd8;

    localparam logic [2:0] CFG_TIMEOUT_TICKS   = 3'd0;
    localparam logic [2:0] CFG_FIND_ENABLE     = 3'd1;
    localparam logic [2:0] CFG_FIND_LENGTH     = 3'd2;
    localparam logic [2:0] CFG_FIND_CHARS_LOW  = 3'd3;
    localparam logic [2:0] CFG_FIND_CHARS_HIGH = 3'd4;

    localparam logic [7:0] CR = 8'h0D;
    localparam logic [7:0] LF = 8'h0A;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic [NUM_TAGS-1:0] tag;
        logic                find;
    } cell_hits_t;

    // Last character of the tag sits in bits [7:0], so byte k is the char k back from the end.
    function automatic logic [TAG_BITS-1:0] tag_text(input int unsigned idx);
        logic [TAG_BITS-1:0] txt;
        case (idx)
            0:       txt = TAG_BITS'({CR, LF, "OK", CR, LF});
            1:       txt = TAG_BITS'({CR, LF, "no change", CR, LF});
            2:       txt = TAG_BITS'({CR, LF, "ready", CR, LF});
            3:       txt = TAG_BITS'({CR, LF, "SEND OK", CR, LF});
            4:       txt = TAG_BITS'({" CONNECT", CR, LF});
            5:       txt = TAG_BITS'({CR, LF, "ERROR", CR, LF});
            6:       txt = TAG_BITS'({CR, LF, "FAIL", CR, LF});
            default: txt = '0;
        endcase
        return txt;
    endfunction

    function automatic logic [4:0] tag_len(input int unsigned idx);
        logic [4:0] len;
        case (idx)
            0:       len = 5'd6;
            1:       len = 5'd13;
            2:       len = 5'd9;
            3:       len = 5'd11;
            4:       len = 5'd10;
            5:       len = 5'd9;
            6:       len = 5'd8;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[rtl/atrtm_cell.sv]
// ============================================================================
// atrtm_cell: one position of the receive window
// Compares the byte arriving at this position against every tag and the find
// string, and holds it for the next position on a shift.
// ============================================================================
`default_nettype none

module atrtm_cell #(
    parameter int unsigned POS = 0
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire atrtm_pkg::cell_ctrl_t              ctrl,
    input  wire logic [7:0]                         data_in,
    input  wire logic [4:0]                         find_len,
    input  wire logic [8*atrtm_pkg::FIND_MAX-1:0]   find_chars,
    output logic [7:0]                              data_out,
    output atrtm_pkg::cell_hits_t                   hits
);

    logic [7:0]                       byte_reg;
    logic [atrtm_pkg::NUM_TAGS-1:0]   tag_m;
    logic                             find_m;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            byte_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            byte_reg <= data_in;
        end
    end

    assign data_out = byte_reg;

    for (genvar t = 0; t < atrtm_pkg::NUM_TAGS; t++)
    begin : g_tag
        localparam logic [atrtm_pkg::TAG_BITS-1:0] TXT = atrtm_pkg::tag_text(t);
        localparam int unsigned LEN = int'(atrtm_pkg::tag_len(t));
        if (POS < LEN)
        begin : g_cmp
            assign tag_m[t] = (data_in == TXT[8*POS +: 8]);
        end
        else
        begin : g_pass
            assign tag_m[t] = 1'b1;
        end
    end

    if (POS < atrtm_pkg::FIND_MAX)
    begin : g_find
        logic [4:0] fidx;
        assign fidx   = find_len - 5'(POS) - 5'd1;
        assign find_m = (5'(POS) >= find_len) ||
                        (data_in == find_chars[8*fidx[3:0] +: 8]);
    end
    else
    begin : g_find_pass
        assign find_m = 1'b1;
    end

    assign hits.tag  = tag_m;
    assign hits.find = find_m;

endmodule

`default_nettype wire

[rtl/at_response_tag_matcher_top.sv]
// ============================================================================
// at_response_tag_matcher_top: modem response tag matcher
// Window of received bytes checked against fixed tags and a find string.
// ============================================================================
// Takes one item per clock cycle while in_ready is high. A byte item shifts
// through a row of window cells; every cell compares the byte landing on it
// against all tags and the find string in the accepting cycle, so the result
// of an item sits in the output register in the cycle after acceptance.
// in_ready drops only while that register holds an untaken result and
// out_ready is low. No clearing pass: a start item clears every window cell together.
`default_nettype none

module at_response_tag_matcher_top #(
    parameter int unsigned WINDOW_LEN = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       finish_code,
    output logic [15:0]      bytes_received,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    logic [15:0] timeout_ticks_reg;
    logic        find_enable_reg;
    logic [4:0]  find_length_reg;
    logic [63:0] find_chars_low_reg;
    logic [63:0] find_chars_high_reg;

    logic [15:0] byte_count_reg, byte_count_next;
    logic [15:0] elapsed_ticks_reg, elapsed_ticks_next;
    logic        search_done_reg, search_done_next;
    logic        out_valid_reg, out_valid_next;
    logic [3:0]  finish_code_reg, finish_code_next;
    logic [15:0] bytes_received_reg, bytes_received_next;

    logic                               in_accept;
    logic                               emit;
    atrtm_pkg::cell_ctrl_t              ctrl;
    logic [7:0]                         chain [WINDOW_LEN+1];
    atrtm_pkg::cell_hits_t              cell_hits [WINDOW_LEN];
    logic [4:0]                         flen;
    logic [8*atrtm_pkg::FIND_MAX-1:0]   find_chars;
    logic [15:0]                        count_inc;
    logic [15:0]                        ticks_inc;
    logic [atrtm_pkg::NUM_TAGS-1:0]     tag_hit;
    logic                               find_hit;
    logic                               any_hit;
    logic [3:0]                         hit_code;

    assign in_ready   = !out_valid_reg || out_ready;
    assign in_accept  = in_valid && in_ready;
    assign flen       = (find_length_reg > 5'd16) ? 5'd16 : find_length_reg;
    assign find_chars = {find_chars_high_reg, find_chars_low_reg};
    assign count_inc  = (byte_count_reg == 16'hFFFF) ? byte_count_reg : byte_count_reg + 16'd1;
    assign ticks_inc  = (elapsed_ticks_reg == 16'hFFFF) ? elapsed_ticks_reg
                                                        : elapsed_ticks_reg + 16'd1;

    assign chain[0] = rx_byte;

    for (genvar k = 0; k < WINDOW_LEN; k++)
    begin : g_cell
        atrtm_cell #(
            .POS        (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .data_in    (chain[k]),
            .find_len   (flen),
            .find_chars (find_chars),
            .data_out   (chain[k+1]),
            .hits       (cell_hits[k])
        );
    end

    always_comb
    begin
        logic [WINDOW_LEN-1:0] tag_all [atrtm_pkg::NUM_TAGS];
        logic [WINDOW_LEN-1:0] find_all;
        for (int k = 0; k < WINDOW_LEN; k++)
        begin
            for (int t = 0; t < atrtm_pkg::NUM_TAGS; t++)
            begin
                tag_all[t][k] = cell_hits[k].tag[t];
            end
            find_all[k] = cell_hits[k].find;
        end
        for (int t = 0; t < atrtm_pkg::NUM_TAGS; t++)
        begin
            tag_hit[t] = (&tag_all[t])
                && (32'(atrtm_pkg::tag_len(t)) <= WINDOW_LEN)
                && (count_inc >= 16'(atrtm_pkg::tag_len(t)));
        end
        find_hit = find_enable_reg && (&find_all)
            && (32'(flen) <= WINDOW_LEN) && (count_inc >= 16'(flen));
        any_hit  = (|tag_hit) || find_hit;
        hit_code = atrtm_pkg::CODE_FIND;
        for (int t = atrtm_pkg::NUM_TAGS - 1; t >= 0; t--)
        begin
            if (tag_hit[t])
            begin
                hit_code = 4'(t);
            end
        end
    end

    always_comb
    begin
        ctrl                = '0;
        emit                = 1'b0;
        byte_count_next     = byte_count_reg;
        elapsed_ticks_next  = elapsed_ticks_reg;
        search_done_next    = search_done_reg;
        finish_code_next    = finish_code_reg;
        bytes_received_next = bytes_received_reg;
        if (in_accept)
        begin
            case (op)
                atrtm_pkg::OP_START:
                begin
                    ctrl.clear         = 1'b1;
                    byte_count_next    = '0;
                    elapsed_ticks_next = '0;
                    search_done_next   = 1'b0;
                end
                atrtm_pkg::OP_BYTE:
                begin
                    if (!search_done_reg)
                    begin
                        if (elapsed_ticks_reg >= timeout_ticks_reg)
                        begin
                            emit                = 1'b1;
                            finish_code_next    = atrtm_pkg::CODE_TIMEOUT;
                            bytes_received_next = byte_count_reg;
                            search_done_next    = 1'b1;
                        end
                        else
                        begin
                            ctrl.shift      = 1'b1;
                            byte_count_next = count_inc;
                            if (any_hit)
                            begin
                                emit                = 1'b1;
                                finish_code_next    = hit_code;
                                bytes_received_next = count_inc;
                                search_done_next    = 1'b1;
                            end
                        end
                    end
                end
                atrtm_pkg::OP_TICK:
                begin
                    if (!search_done_reg)
                    begin
                        elapsed_ticks_next = ticks_inc;
                        if (ticks_inc >= timeout_ticks_reg)
                        begin
                            emit                = 1'b1;
                            finish_code_next    = atrtm_pkg::CODE_TIMEOUT;
                            bytes_received_next = byte_count_reg;
                            search_done_next    = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg   <= 16'd1000;
            find_enable_reg     <= 1'b0;
            find_length_reg     <= 5'd1;
            find_chars_low_reg  <= '0;
            find_chars_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                atrtm_pkg::CFG_TIMEOUT_TICKS:   timeout_ticks_reg   <= cfg_data[15:0];
                atrtm_pkg::CFG_FIND_ENABLE:     find_enable_reg     <= cfg_data[0];
                atrtm_pkg::CFG_FIND_LENGTH:     find_length_reg     <= cfg_data[4:0];
                atrtm_pkg::CFG_FIND_CHARS_LOW:  find_chars_low_reg  <= cfg_data;
                atrtm_pkg::CFG_FIND_CHARS_HIGH: find_chars_high_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            elapsed_ticks_reg <= '0;
            search_done_reg   <= 1'b1;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            byte_count_reg    <= byte_count_next;
            elapsed_ticks_reg <= elapsed_ticks_next;
            search_done_reg   <= search_done_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        finish_code_reg    <= finish_code_next;
        bytes_received_reg <= bytes_received_next;
    end

    assign out_valid      = out_valid_reg;
    assign finish_code    = finish_code_reg;
    assign bytes_received = bytes_received_reg;

    // start wipes the whole window, oldest cell included
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && op == atrtm_pkg::OP_START |=> chain[WINDOW_LEN] == 8'd0)
        else $error("window not cleared by start item");

    // an idle search never raises a new result
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && search_done_reg && op != atrtm_pkg::OP_START
        |=> out_valid == $past(out_valid_reg && !out_ready))
        else $error("result from idle search");

    // a result ends the search
    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> search_done_reg && out_valid)
        else $error("result did not end search");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> finish_code <= atrtm_pkg::CODE_TIMEOUT)
        else $error("finish code out of range");

endmodule

`default_nettype wire

[test/at_response_tag_matcher_top_test.sv]
`timescale 1ns / 100ps
// ============================================================================
// at_response_tag_matcher_top_test: response tag matcher testbench
// Sends start, byte and tick items and keeps its own copy of the search window.
// Each result is checked in order against the predicted tag, find or timeout.
// Runs a directed part, then random searches under several register settings.
// ============================================================================
`default_nettype none

module at_response_tag_matcher_top_test;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         WIN_LEN    = 16;
    localparam int         IDLE_LIMIT = 3000;
    localparam int         PHASE_ITEMS = 310;
    localparam int         HOLD_CYCLES = 400;

    typedef struct {
        logic [1:0] op;
        logic [7:0] data;
    } rx_item_t;

    typedef struct {
        logic [3:0]  code;
        logic [15:0] count;
    } finish_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  op = atrtm_pkg::OP_START;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  finish_code;
    logic [15:0] bytes_received;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = atrtm_pkg::CFG_TIMEOUT_TICKS;
    logic [63:0] cfg_data = 64'd0;

    rx_item_t tx_items [$];
    finish_t  finish_due [$];

    // predicted block state
    logic [7:0]  win [WIN_LEN];
    logic [15:0] seen_bytes = 16'd0;
    logic [15:0] ticks_seen = 16'd0;
    bit          search_over = 1'b1;
    logic [15:0] limit_ticks = 16'd1000;
    bit          find_on = 1'b0;
    logic [4:0]  find_len = 5'd1;
    logic [63:0] find_lo = 64'd0;
    logic [63:0] find_hi = 64'd0;

    string tag_txt [7] = '{
        "\015\012OK\015\012",
        "\015\012no change\015\012",
        "\015\012ready\015\012",
        "\015\012SEND OK\015\012",
        " CONNECT\015\012",
        "\015\012ERROR\015\012",
        "\015\012FAIL\015\012"
    };
    string alpha = "\015\012 OKERFAILSNDCnoady";

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_ask = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int fail_count = 0;
    int queued = 0;

    at_response_tag_matcher_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .finish_code    (finish_code),
        .bytes_received (bytes_received),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic logic [7:0] find_char(input int i);
        return (i < 8) ? find_lo[8*i +: 8] : find_hi[8*(i-8) +: 8];
    endfunction

    function automatic bit tail_is(input logic [7:0] pat [WIN_LEN], input int n);
        int k;
        if (n > WIN_LEN || int'(seen_bytes) < n)
            return 1'b0;
        for (k = 0; k < n; k++)
            if (win[k] != pat[n-1-k])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic track_response(input logic [1:0] kind, input logic [7:0] ch);
        logic [7:0] pat [WIN_LEN];
        finish_t    res;
        string      s;
        int         hit;
        int         n;
        int         i;
        int         t;
        hit = -1;
        case (kind)
            atrtm_pkg::OP_START:
            begin
                for (i = 0; i < WIN_LEN; i++)
                    win[i] = 8'h00;
                seen_bytes  = 16'd0;
                ticks_seen  = 16'd0;
                search_over = 1'b0;
            end
            atrtm_pkg::OP_TICK:
            begin
                if (!search_over)
                begin
                    if (ticks_seen != 16'hFFFF)
                        ticks_seen++;
                    if (ticks_seen >= limit_ticks)
                        hit = int'(atrtm_pkg::CODE_TIMEOUT);
                end
            end
            atrtm_pkg::OP_BYTE:
            begin
                if (!search_over && ticks_seen >= limit_ticks)
                    hit = int'(atrtm_pkg::CODE_TIMEOUT);
                else if (!search_over)
                begin
                    for (i = WIN_LEN - 1; i > 0; i--)
                        win[i] = win[i-1];
                    win[0] = ch;
                    if (seen_bytes != 16'hFFFF)
                        seen_bytes++;
                    if (find_on)
                    begin
                        n = (find_len > 5'd16) ? 16 : int'(find_len);
                        for (i = 0; i < WIN_LEN; i++)
                            pat[i] = find_char(i);
                        if (tail_is(pat, n))
                            hit = int'(atrtm_pkg::CODE_FIND);
                    end
                    // lowest tag index wins
                    for (t = 6; t >= 0; t--)
                    begin
                        s = tag_txt[t];
                        for (i = 0; i < s.len(); i++)
                            pat[i] = s[i];
                        if (tail_is(pat, s.len()))
                            hit = t;
                    end
                end
            end
            default: ;
        endcase
        if (hit >= 0)
        begin
            res.code  = hit[3:0];
            res.count = seen_bytes;
            finish_due.push_back(res);
            search_over = 1'b1;
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        rx_item_t nxt;
        bit       take;
        if (rst_n)
        begin
            take = in_valid && in_ready;
            if (take)
                track_response(op, rx_byte);
            if (in_valid && !take)
                ;
            else if (tx_items.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                nxt = tx_items.pop_front();
                in_valid <= 1'b1;
                op       <= nxt.op;
                rx_byte  <= nxt.data;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver
    always @(posedge clk)
    begin
        if (hold_ask != hold_seen)
        begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        finish_t exp;
        if (rst_n && out_valid && out_ready)
        begin
            if (finish_due.size() == 0)
            begin
                $display("%0t: unexpected result: code %0d count %0d",
                         $time, finish_code, bytes_received);
                fail_count++;
            end
            else
            begin
                exp = finish_due.pop_front();
                if (finish_code !== exp.code)
                begin
                    $display("%0t: finish_code expected %0d actual %0d",
                             $time, exp.code, finish_code);
                    fail_count++;
                end
                if (bytes_received !== exp.count)
                begin
                    $display("%0t: bytes_received expected %0d actual %0d",
                             $time, exp.count, bytes_received);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("at_response_tag_matcher_top_test: FAIL");
                $finish;
            end
        end
    end

    task automatic push_item(input logic [1:0] kind, input logic [7:0] ch);
        rx_item_t it;
        it.op   = kind;
        it.data = ch;
        tx_items.push_back(it);
        queued++;
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_item(atrtm_pkg::OP_BYTE, s[i]);
    endtask

    function automatic logic [7:0] rand_char();
        if ($urandom_range(1))
            return 8'($urandom_range(255));
        return alpha[$urandom_range(alpha.len() - 1)];
    endfunction

    task automatic wait_quiet();
        do
            @(negedge clk);
        while (tx_items.size() != 0 || in_valid || finish_due.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            atrtm_pkg::CFG_TIMEOUT_TICKS:   limit_ticks = val[15:0];
            atrtm_pkg::CFG_FIND_ENABLE:     find_on     = val[0];
            atrtm_pkg::CFG_FIND_LENGTH:     find_len    = val[4:0];
            atrtm_pkg::CFG_FIND_CHARS_LOW:  find_lo     = val;
            atrtm_pkg::CFG_FIND_CHARS_HIGH: find_hi     = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic setup_search(input logic [15:0] tmo, input bit en, input logic [4:0] len,
                                input logic [63:0] lo, input logic [63:0] hi);
        write_reg(atrtm_pkg::CFG_TIMEOUT_TICKS, {48'd0, tmo});
        write_reg(atrtm_pkg::CFG_FIND_ENABLE, {63'd0, en});
        write_reg(atrtm_pkg::CFG_FIND_LENGTH, {59'd0, len});
        write_reg(atrtm_pkg::CFG_FIND_CHARS_LOW, lo);
        write_reg(atrtm_pkg::CFG_FIND_CHARS_HIGH, hi);
    endtask

    // one search: start, filler, then a tag, the find string, a broken tag or ticks, then up to two random items
    task automatic queue_search();
        string s;
        int    fill;
        int    kind;
        int    n;
        int    i;
        int    k;
        push_item(atrtm_pkg::OP_START, 8'($urandom_range(255)));
        fill = $urandom_range(18);
        for (i = 0; i < fill; i++)
        begin
            if ($urandom_range(99) < 8)
                push_item(atrtm_pkg::OP_TICK, 8'($urandom_range(255)));
            else
                push_item(atrtm_pkg::OP_BYTE, rand_char());
        end
        kind = $urandom_range(9);
        if (kind < 5)
            push_text(tag_txt[$urandom_range(6)]);
        else if (kind < 7)
        begin
            n = (find_len > 5'd16) ? 16 : int'(find_len);
            for (i = 0; i < n; i++)
                push_item(atrtm_pkg::OP_BYTE, find_char(i));
        end
        else if (kind < 8)
        begin
            s = tag_txt[$urandom_range(6)];
            k = $urandom_range(s.len() - 1);
            for (i = 0; i < s.len(); i++)
            begin
                if (i != k)
                    push_item(atrtm_pkg::OP_BYTE, s[i]);
                else if ($urandom_range(1))
                    push_item(atrtm_pkg::OP_BYTE, s[i] ^ 8'h20);
            end
        end
        else
        begin
            n = (limit_ticks <= 16'd64) ? int'(limit_ticks) + 1 : 3;
            repeat (n) push_item(atrtm_pkg::OP_TICK, 8'($urandom_range(255)));
            push_item(atrtm_pkg::OP_BYTE, rand_char());
            push_item(atrtm_pkg::OP_BYTE, rand_char());
        end
        repeat ($urandom_range(2))
            push_item(2'($urandom_range(3)), 8'($urandom_range(255)));
    endtask

    initial
    begin
        logic [15:0] tmo_set [6] = '{16'hFFFF, 16'd12, 16'd1, 16'd30, 16'd8, 16'd1000};
        bit          en_set  [6] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
        logic [4:0]  len_set [6] = '{5'd16, 5'd5, 5'd16, 5'd31, 5'd3, 5'd12};
        logic [63:0] lo;
        logic [63:0] hi;
        int          p;

        tx_idle_pct = 13;
        rx_idle_pct = 72;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // idle block ignores bytes, ticks and the unused op
        push_item(atrtm_pkg::OP_BYTE, 8'h41);
        push_item(atrtm_pkg::OP_TICK, 8'h00);
        push_item(OP_UNUSED, 8'hFF);
        push_item(atrtm_pkg::OP_START, 8'h00);
        push_text(tag_txt[0]);
        push_item(atrtm_pkg::OP_BYTE, 8'h78);
        wait_quiet();
        // tick timeout
        write_reg(atrtm_pkg::CFG_TIMEOUT_TICKS, 64'd2);
        push_item(atrtm_pkg::OP_START, 8'h00);
        push_item(atrtm_pkg::OP_TICK, 8'h00);
        push_item(atrtm_pkg::OP_TICK, 8'h00);
        wait_quiet();
        // zero timeout: first byte times out
        write_reg(atrtm_pkg::CFG_TIMEOUT_TICKS, 64'd0);
        push_item(atrtm_pkg::OP_START, 8'h00);
        push_item(atrtm_pkg::OP_BYTE, 8'h55);
        wait_quiet();
        // time already used up when the byte comes
        write_reg(atrtm_pkg::CFG_TIMEOUT_TICKS, 64'd1000);
        push_item(atrtm_pkg::OP_START, 8'h00);
        push_item(atrtm_pkg::OP_TICK, 8'h00);
        push_item(atrtm_pkg::OP_TICK, 8'h00);
        wait_quiet();
        write_reg(atrtm_pkg::CFG_TIMEOUT_TICKS, 64'd1);
        push_item(atrtm_pkg::OP_BYTE, 8'h31);
        wait_quiet();
        // empty find string hits on the first byte
        write_reg(atrtm_pkg::CFG_TIMEOUT_TICKS, 64'hFFFF);
        write_reg(atrtm_pkg::CFG_FIND_ENABLE, 64'd1);
        write_reg(atrtm_pkg::CFG_FIND_LENGTH, 64'd0);
        push_item(atrtm_pkg::OP_START, 8'h00);
        push_item(atrtm_pkg::OP_BYTE, 8'hFF);
        wait_quiet();
        // zero chars against a cleared window need the full length first
        write_reg(atrtm_pkg::CFG_FIND_LENGTH, 64'd3);
        push_item(atrtm_pkg::OP_START, 8'h00);
        repeat (3) push_item(atrtm_pkg::OP_BYTE, 8'h00);
        wait_quiet();
        // tag beats the find string
        write_reg(atrtm_pkg::CFG_FIND_CHARS_LOW,
                  {40'd0, atrtm_pkg::LF, atrtm_pkg::CR, 8'h4B});
        push_item(atrtm_pkg::OP_START, 8'h00);
        push_text(tag_txt[0]);
        wait_quiet();

        for (p = 0; p < 6; p++)
        begin
            tx_idle_pct = (p < 2) ? 13 : (p < 4) ? 72 : 0;
            rx_idle_pct = (p < 2) ? 72 : (p < 4) ? 13 : 0;
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            if (p == 2)
                lo = '1;
            setup_search(tmo_set[p], en_set[p], len_set[p], lo, hi);
            queued = 0;
            while (queued < PHASE_ITEMS)
            begin
                if ($urandom_range(9) == 0)
                    repeat ($urandom_range(1, 4))
                        push_item(2'($urandom_range(3)), 8'($urandom_range(255)));
                else
                    queue_search();
            end
            if (p == 4)
                hold_ask++;
            wait_quiet();
        end

        repeat (5) @(negedge clk);
        if (finish_due.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, finish_due.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("at_response_tag_matcher_top_test: PASS");
        else
            $display("at_response_tag_matcher_top_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
rtl/atrtm_pkg.sv
rtl/atrtm_cell.sv
rtl/at_response_tag_matcher_top.sv
test/at_response_tag_matcher_top_test.sv
